/* rtl/tws_pkg.sv */
// Package for the trie word store: sizes, command and status codes, controller state type
// and the command/status bundles between controller and datapath.
// No dependencies.
package tws_pkg;

    // Node pool and alphabet
    localparam int NODES    = 1024;
    localparam int ALPHABET = 26;

    // Derived widths
    localparam int NODE_W  = $clog2(NODES);
    localparam int FREE_W  = NODE_W + 1;
    localparam int CODE_W  = 5;
    localparam int LANE_W  = $clog2(ALPHABET);
    // one child field: word mark of the child, then the child pointer
    localparam int FIELD_W = NODE_W + 1;
    localparam int ROW_W   = ALPHABET * FIELD_W;

    // Item command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Result status codes
    localparam logic STS_OK        = 1'b0;
    localparam logic STS_POOL_FULL = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;   // write one zero row of the node memory
        logic load;    // capture the input beat and read the current node's row
        logic step;    // walk one letter, update the trie, emit a result on last
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;  // sweep is on its final row
        logic item_last;   // held beat ends a word
        logic out_busy;    // result register full and not draining
    } t_dp_stat;

endpackage

/* rtl/tws_in_if.sv */
// Input channel of the trie word store: one letter beat with its command.
// Depends on tws_pkg for field widths.
interface tws_in_if;
    import tws_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [CODE_W-1:0] letter;
    logic              has_letter;
    logic              last;

    modport source (output valid, command, letter, has_letter, last, input ready);
    modport sink   (input valid, command, letter, has_letter, last, output ready);

endinterface

/* rtl/tws_out_if.sv */
// Result channel of the trie word store: found flag and status per word.
// No dependencies.
interface tws_out_if;

    logic valid;
    logic ready;
    logic found;
    logic status;

    modport source (output valid, found, status, input ready);
    modport sink   (input valid, found, status, output ready);

endinterface

/* rtl/trie_word_store_top.sv */
// Trie word store: letters walk a prefix trie held in a node memory.
// The accepted beat and its node row are registered; the walk step then
// writes the result register, and a word end's step waits while it is full
// and not draining. Each letter needs that row read before its step; no new
// letter is accepted until the step is taken. Reset: synchronous; a clearing
// sweep zeroes all 1024 (NODES) node rows; no beat is accepted until it ends.
module trie_word_store_top
    import tws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tws_in_if.sink    i_in,
    tws_out_if.source o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    assign i_in.ready = in_ready;

    // Sequencing
    tws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (dp_stat),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    // Trie storage and walk
    tws_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_in.command),
        .i_letter     (i_in.letter),
        .i_has_letter (i_in.has_letter),
        .i_last       (i_in.last),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_found      (o_out.found),
        .o_status     (o_out.status)
    );

endmodule

/* rtl/tws_ctrl.sv */
// Controller of the trie word store: clearing sweep, beat acceptance, walk step.
// Depends on tws_pkg.
module tws_ctrl
    import tws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd.clear = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.step  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                // a word end waits for room in the result register
                if (!(i_stat.item_last && i_stat.out_busy)) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/tws_dp.sv */
// Datapath of the trie word store: node memory, walk registers, free counter
// and result register. Depends on tws_pkg.
module tws_dp
    import tws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_command,
    input  logic [CODE_W-1:0] i_letter,
    input  logic              i_has_letter,
    input  logic              i_last,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_found,
    output logic              o_status
);

    // Node memory: one row per node, one field per letter (child mark, child ptr)
    logic [ROW_W-1:0]   r_node_mem [NODES];
    logic [ROW_W-1:0]   r_row;

    // Held beat
    logic               r_command;
    logic [CODE_W-1:0]  r_letter;
    logic               r_has;
    logic               r_last;

    // Walk state
    logic [NODE_W-1:0]  r_cur,       n_cur;
    logic [NODE_W-1:0]  r_par,       n_par;
    logic [LANE_W-1:0]  r_plane,     n_plane;
    logic               r_cur_mark,  n_cur_mark;
    logic               r_root_mark, n_root_mark;
    logic               r_broken,    n_broken;
    logic               r_full,      n_full;
    logic [FREE_W-1:0]  r_next_free, n_next_free;
    logic [NODE_W-1:0]  r_clr;

    // Result register
    logic               r_out_valid;
    logic               r_found,  n_found;
    logic               r_status, n_status;

    // Walk step signals
    logic               code_ok;
    logic [LANE_W-1:0]  lane;
    logic [FIELD_W-1:0] field;
    logic [NODE_W-1:0]  child;
    logic               stepped;
    logic [NODE_W-1:0]  step_node;
    logic               step_mark;
    logic               brk;
    logic               full;
    logic [NODE_W-1:0]  end_node;
    logic               end_mark;
    logic [NODE_W-1:0]  end_par;
    logic [LANE_W-1:0]  end_lane;
    logic               brk_f;
    logic               full_f;
    logic               is_insert;
    logic               wr_en;
    logic [NODE_W-1:0]  wr_addr;
    logic [LANE_W-1:0]  wr_lane;
    logic [FIELD_W-1:0] wr_data;

    assign lane  = r_letter[LANE_W-1:0];
    assign code_ok = int'(r_letter) < ALPHABET;
    assign field = r_row[int'(lane)*FIELD_W +: FIELD_W];
    assign child = field[NODE_W-1:0];
    assign is_insert = (r_command == CMD_INSERT);

    // Walk one letter and settle the word end
    always_comb begin
        stepped     = 1'b0;
        step_node   = r_cur;
        step_mark   = 1'b0;
        brk         = 1'b0;
        full        = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_cur;
        wr_lane     = lane;
        wr_data     = '0;
        n_next_free = r_next_free;
        n_root_mark = r_root_mark;
        n_found     = r_found;
        n_status    = r_status;

        if (r_has && !r_broken) begin
            if (!code_ok) begin
                brk = 1'b1;
            end else if (child != '0) begin
                stepped   = 1'b1;
                step_node = child;
                step_mark = field[FIELD_W-1];
            end else if (!is_insert) begin
                brk = 1'b1;
            end else if (r_next_free == FREE_W'(NODES)) begin
                brk  = 1'b1;
                full = 1'b1;
            end else begin
                // take a fresh node and link it
                stepped     = 1'b1;
                step_node   = r_next_free[NODE_W-1:0];
                step_mark   = 1'b0;
                wr_en       = 1'b1;
                wr_data     = {1'b0, r_next_free[NODE_W-1:0]};
                n_next_free = r_next_free + FREE_W'(1);
            end
        end

        end_node = stepped ? step_node : r_cur;
        end_mark = stepped ? step_mark : ((r_cur == '0) ? r_root_mark : r_cur_mark);
        end_par  = stepped ? r_cur : r_par;
        end_lane = stepped ? lane : r_plane;
        brk_f    = r_broken | brk;
        full_f   = r_full | full;

        n_cur      = end_node;
        n_par      = end_par;
        n_plane    = end_lane;
        n_cur_mark = end_mark;
        n_broken   = brk_f;
        n_full     = full_f;

        if (r_last) begin
            n_found  = !brk_f && (is_insert || end_mark);
            n_status = (is_insert && full_f) ? STS_POOL_FULL : STS_OK;
            // mark lives in the parent's field, or in a register for the root
            if (!brk_f && is_insert) begin
                if (end_node == '0) begin
                    n_root_mark = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = end_par;
                    wr_lane = end_lane;
                    wr_data = {1'b1, end_node};
                end
            end
            n_cur    = '0;
            n_broken = 1'b0;
            n_full   = 1'b0;
        end
    end

    // Node memory: clearing sweep or one field write; registered row read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_node_mem[r_clr] <= '0;
        end else if (i_cmd.step && wr_en) begin
            r_node_mem[wr_addr][int'(wr_lane)*FIELD_W +: FIELD_W] <= wr_data;
        end
        if (i_cmd.load) begin
            r_row <= r_node_mem[r_cur];
        end
    end

    // Held beat and walk payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_letter  <= i_letter;
            r_has     <= i_has_letter;
            r_last    <= i_last;
        end
        if (i_cmd.step) begin
            r_par      <= n_par;
            r_plane    <= n_plane;
            r_cur_mark <= n_cur_mark;
        end
        if (i_cmd.step && r_last) begin
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_root_mark <= 1'b0;
            r_broken    <= 1'b0;
            r_full      <= 1'b0;
            r_next_free <= FREE_W'(1);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            if (i_cmd.step) begin
                r_cur       <= n_cur;
                r_root_mark <= n_root_mark;
                r_broken    <= n_broken;
                r_full      <= n_full;
                r_next_free <= n_next_free;
            end
            if (i_cmd.step && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clear_last = (r_clr == NODE_W'(NODES - 1));
    assign o_stat.item_last  = r_last;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_status    = r_status;

endmodule

/* tb/trie_word_store_checker.sv */
// Checker for the trie word store: watches the letter and result channels,
// keeps its own copy of the trie and compares every result beat with it.
// Depends on tws_pkg, tws_in_if and tws_out_if.
module trie_word_store_checker
    import tws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tws_in_if    i_in_mon,
    tws_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic found;
        logic status;
    } t_word_result;

    // Shadow trie: child pointers per node and letter, word marks per node
    logic [NODE_W-1:0] kid_ptr  [NODES*ALPHABET];
    logic              word_end [NODES];
    logic [NODE_W-1:0] walk_node;
    logic [FREE_W-1:0] free_next;
    logic              walk_dead;
    logic              pool_dry;

    t_word_result word_results_q [$];
    int           fail_tally = 0;

    function automatic void trie_clear();
        foreach (kid_ptr[i]) kid_ptr[i] = '0;
        foreach (word_end[i]) word_end[i] = 1'b0;
        walk_node = '0;
        free_next = FREE_W'(1);
        walk_dead = 1'b0;
        pool_dry  = 1'b0;
    endfunction

    // One letter beat: walk or grow the trie; returns 1 when a word ends
    function automatic bit trie_step(input logic cmd, input logic [CODE_W-1:0] code,
                                     input logic has, input logic fin,
                                     output t_word_result res);
        int                slot;
        logic [NODE_W-1:0] nxt;
        res = '0;
        if (has && !walk_dead) begin
            if (int'(code) >= ALPHABET) begin
                walk_dead = 1'b1;
            end else begin
                slot = int'(walk_node) * ALPHABET + int'(code);
                nxt  = kid_ptr[slot];
                if (nxt != '0) begin
                    walk_node = nxt;
                end else if (cmd == CMD_SEARCH) begin
                    walk_dead = 1'b1;
                end else if (int'(free_next) >= NODES) begin
                    walk_dead = 1'b1;
                    pool_dry  = 1'b1;
                end else begin
                    nxt           = free_next[NODE_W-1:0];
                    free_next     = free_next + FREE_W'(1);
                    kid_ptr[slot] = nxt;
                    walk_node     = nxt;
                end
            end
        end
        if (!fin) return 1'b0;
        // end of word: mark on insert, report the mark
        if (!walk_dead) begin
            if (cmd == CMD_INSERT) word_end[walk_node] = 1'b1;
            res.found = word_end[walk_node];
        end
        res.status = (cmd == CMD_INSERT && pool_dry) ? STS_POOL_FULL : STS_OK;
        walk_node = '0;
        walk_dead = 1'b0;
        pool_dry  = 1'b0;
        return 1'b1;
    endfunction

    // Compare result beats first, then predict from the letter beat
    always @(posedge i_clk) begin : watch
        t_word_result want;
        t_word_result made;
        if (!i_rst_n) begin
            trie_clear();
            word_results_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (word_results_q.size() == 0) begin
                    fail_tally++;
                    $error("result beat with no word pending: found %0b status %0b",
                           i_out_mon.found, i_out_mon.status);
                end else begin
                    want = word_results_q.pop_front();
                    if (i_out_mon.found !== want.found) begin
                        fail_tally++;
                        $error("found: expected %0b, got %0b", want.found,
                               i_out_mon.found);
                    end
                    if (i_out_mon.status !== want.status) begin
                        fail_tally++;
                        $error("status: expected %0b, got %0b", want.status,
                               i_out_mon.status);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (trie_step(i_in_mon.command, i_in_mon.letter, i_in_mon.has_letter,
                              i_in_mon.last, made))
                    word_results_q.insert(word_results_q.size(), made);
            end
        end
        o_pending    <= word_results_q.size();
        o_fail_count <= fail_tally;
    end

endmodule

/* tb/trie_word_store_top_test.sv */
// Testbench top for the trie word store: drives words letter by letter with
// random gaps and result back-pressure; the checker module judges the results.
// Depends on tws_pkg, tws_in_if, tws_out_if, trie_word_store_top and the checker.
module trie_word_store_top_test;
    import tws_pkg::*;

    localparam int RUN_BEATS   = 1600;
    localparam int FILL_FROM   = 900;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int KEEP_MAX    = 512;
    localparam int WORD_MAX    = 16;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   words_pending;
    int   beats_sent = 0;
    int   cycles     = 0;

    // Current word and the words inserted so far, for searches that hit
    logic [CODE_W-1:0] word_buf   [WORD_MAX];
    logic [CODE_W-1:0] kept_words [KEEP_MAX][WORD_MAX];
    int                kept_len   [KEEP_MAX];
    int                kept_count = 0;

    tws_in_if  in_ch();
    tws_out_if out_ch();

    trie_word_store_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    trie_word_store_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One letter beat, after a random gap; returns once it is accepted
    task automatic send_beat(input logic cmd, input logic [CODE_W-1:0] code,
                             input logic has, input logic fin);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if ((beats_sent / 200) % 4 != 0) begin
            if (r >= 92)      gap = $urandom_range(8, 30);
            else if (r >= 55) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.letter     <= code;
        in_ch.has_letter <= has;
        in_ch.last       <= fin;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_word(input logic cmd, input int n);
        if (n == 0) begin
            send_beat(cmd, CODE_W'($urandom_range(0, 31)), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++)
            send_beat(cmd, word_buf[i], 1'b1, i == n - 1);
    endtask

    // Narrow letters share prefixes; the full alphabet mostly takes new nodes
    task automatic fill_random(input int n, input bit narrow);
        for (int i = 0; i < n; i++)
            word_buf[i] = narrow ? CODE_W'($urandom_range(0, 3))
                                 : CODE_W'($urandom_range(0, ALPHABET - 1));
    endtask

    task automatic keep_word(input int n);
        int k;
        if (n == 0) return;
        if (kept_count < KEEP_MAX) begin
            k = kept_count;
            kept_count++;
        end else begin
            k = $urandom_range(0, KEEP_MAX - 1);
        end
        for (int i = 0; i < n; i++) kept_words[k][i] = word_buf[i];
        kept_len[k] = n;
    endtask

    // Search a stored word, now and then only a prefix of it
    task automatic search_kept();
        int k;
        int n;
        k = $urandom_range(0, kept_count - 1);
        n = kept_len[k];
        for (int i = 0; i < n; i++) word_buf[i] = kept_words[k][i];
        if (n > 1 && $urandom_range(0, 3) == 0) n = $urandom_range(1, n - 1);
        send_word(CMD_SEARCH, n);
    endtask

    // Broken words: mixed commands, codes past the alphabet, letterless beats
    task automatic send_noise_word(input int n);
        logic              base;
        logic              cmd;
        logic              has;
        logic [CODE_W-1:0] code;
        base = ($urandom_range(0, 1) != 0) ? CMD_SEARCH : CMD_INSERT;
        if (n == 0) begin
            send_beat(base, CODE_W'($urandom_range(0, 31)), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            cmd = base;
            if ($urandom_range(0, 9) < 3)
                cmd = ($urandom_range(0, 1) != 0) ? CMD_SEARCH : CMD_INSERT;
            has  = ($urandom_range(0, 7) != 0);
            code = ($urandom_range(0, 5) == 0) ? CODE_W'($urandom_range(ALPHABET, 31))
                                               : CODE_W'($urandom_range(0, ALPHABET - 1));
            if (!has) code = CODE_W'($urandom_range(0, 31));
            send_beat(cmd, code, has, i == n - 1);
        end
    endtask

    // Result side: random stalls, calm stretches and two long hold-offs
    initial begin : drain_ctl
        int stall_left;
        int drained;
        int r;
        bit held_early;
        bit held_late;
        stall_left = 0;
        drained    = 0;
        held_early = 1'b0;
        held_late  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) drained++;
            if (stall_left > 0) begin
                stall_left--;
            end else if (!held_early && drained >= 20) begin
                held_early = 1'b1;
                stall_left = 600;
            end else if (!held_late && drained >= 150) begin
                held_late  = 1'b1;
                stall_left = 600;
            end else if ((cycles / 3000) % 3 != 0) begin
                r = $urandom_range(0, 99);
                if (r >= 96)      stall_left = $urandom_range(15, 60);
                else if (r >= 70) stall_left = $urandom_range(1, 3);
            end
            out_ch.ready <= (stall_left == 0);
        end
    end

    // Letter side: reset, directed words, random words, then the verdict
    initial begin : stimulus
        int r;
        int n;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_INSERT;
        in_ch.letter     <= '0;
        in_ch.has_letter <= 1'b0;
        in_ch.last       <= 1'b0;
        rst_n            <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty word: absent on a bare trie, then inserted at the root
        send_beat(CMD_SEARCH, 5'd31, 1'b0, 1'b1);
        send_beat(CMD_INSERT, 5'd0,  1'b0, 1'b1);
        send_beat(CMD_SEARCH, 5'd0,  1'b0, 1'b1);
        // "az": whole word, unmarked prefix, tail alone
        send_beat(CMD_INSERT, 5'd0,  1'b1, 1'b0);
        send_beat(CMD_INSERT, 5'd25, 1'b1, 1'b1);
        send_beat(CMD_SEARCH, 5'd0,  1'b1, 1'b0);
        send_beat(CMD_SEARCH, 5'd25, 1'b1, 1'b1);
        send_beat(CMD_SEARCH, 5'd0,  1'b1, 1'b1);
        send_beat(CMD_SEARCH, 5'd25, 1'b1, 1'b1);
        // codes past the alphabet break the path
        send_beat(CMD_INSERT, 5'd1,  1'b1, 1'b0);
        send_beat(CMD_INSERT, 5'd31, 1'b1, 1'b0);
        send_beat(CMD_INSERT, 5'd2,  1'b1, 1'b1);
        send_beat(CMD_INSERT, 5'd26, 1'b1, 1'b1);
        send_beat(CMD_SEARCH, 5'd31, 1'b1, 1'b1);
        // letterless beat inside a word is skipped
        send_beat(CMD_INSERT, 5'd1,  1'b1, 1'b0);
        send_beat(CMD_INSERT, 5'd17, 1'b0, 1'b0);
        send_beat(CMD_INSERT, 5'd2,  1'b1, 1'b1);
        send_beat(CMD_SEARCH, 5'd1,  1'b1, 1'b0);
        send_beat(CMD_SEARCH, 5'd2,  1'b1, 1'b1);
        // mixed commands within one word
        send_beat(CMD_INSERT, 5'd3,  1'b1, 1'b0);
        send_beat(CMD_SEARCH, 5'd4,  1'b1, 1'b1);
        send_beat(CMD_SEARCH, 5'd0,  1'b1, 1'b0);
        send_beat(CMD_INSERT, 5'd25, 1'b1, 1'b1);

        // mixed traffic: inserts, hitting searches, misses and broken words
        while (beats_sent < FILL_FROM) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                n = ($urandom_range(0, 49) == 0) ? 0 : $urandom_range(1, 8);
                fill_random(n, $urandom_range(0, 3) == 0);
                send_word(CMD_INSERT, n);
                keep_word(n);
            end else if (r < 65 && kept_count > 0) begin
                search_kept();
            end else if (r < 82) begin
                n = $urandom_range(1, 6);
                fill_random(n, $urandom_range(0, 1) == 0);
                send_word(CMD_SEARCH, n);
            end else begin
                send_noise_word($urandom_range(0, 8));
            end
        end

        // long inserts drain the node pool; stored words are still searched
        while (beats_sent < RUN_BEATS) begin
            if ($urandom_range(0, 99) < 75 || kept_count == 0) begin
                n = $urandom_range(10, WORD_MAX);
                fill_random(n, 1'b0);
                send_word(CMD_INSERT, n);
                keep_word(n);
            end else begin
                search_kept();
            end
        end
        in_ch.valid <= 1'b0;

        do @(posedge clk); while (words_pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
